@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SJFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define SJFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sjfp_pkg.sv @@
`default_nettype none

package sjfp_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int CENTER_W    = 10;
    localparam logic [CENTER_W-1:0] CENTER = CENTER_W'(512);
    localparam logic [7:0] CMD_BASE = 8'h80;
    localparam logic [1:0] LED_MASK = 2'b11;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_BITS   = 2'd2;
    localparam int CFG_DATA_W = 8;

    // Direction codes
    localparam logic [2:0] DIR_NONE   = 3'd0;
    localparam logic [2:0] DIR_X_HIGH = 3'd1;
    localparam logic [2:0] DIR_X_LOW  = 3'd2;
    localparam logic [2:0] DIR_Y_HIGH = 3'd3;
    localparam logic [2:0] DIR_Y_LOW  = 3'd4;

    // Request function codes
    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic       func;
        logic       byte_done;
        logic [7:0] rx_byte;
    } sjfp_in_t;

    typedef struct packed {
        logic        chip_select;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [7:0]  buttons;
        logic [2:0]  direction;
    } sjfp_out_t;

endpackage

`default_nettype wire

@@ rtl/sjfp_out_buf.sv @@
`default_nettype none

// Two-entry output buffer: main register plus skid register.
module sjfp_out_buf
    import sjfp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire sjfp_out_t push_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output sjfp_out_t      out_data
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    sjfp_out_t main_data_reg, main_data_next;
    sjfp_out_t skid_data_reg, skid_data_next;

    logic push;
    logic pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

@@ rtl/spi_joystick_frame_poller_top.sv @@
// SPI joystick frame poller: master-side sequencer for a five-byte poll.
// Input channel (in_valid/in_ready/in_data): each request is either a step
// tick (func = 0, with byte_done and rx_byte from the SPI engine) or a read
// request (func = 1) that returns and clears the pending direction code.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// request, carrying chip select, the byte to start, the latest X/Y/buttons
// and, on a read, the direction code.
// Config port: cfg_we/cfg_index/cfg_data, to be written only while the block
// idles; the user must keep to this, as the block itself does not enforce it.
// Throughput: one request per cycle while in_ready is high; the step logic sits
// between the state registers and a two-entry output buffer.
// Receiver stall: the buffer holds the waiting result plus one more; in_ready
// drops once both are full and rises the cycle after a result is taken.
// Reset: chip select high, sequencer in the start phase, frame bytes,
// pending direction and config registers zero, output buffer empty.
`default_nettype none

module spi_joystick_frame_poller_top
    import sjfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sjfp_in_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sjfp_out_t                   out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        PH_RX0   = 3'd0,
        PH_RX1   = 3'd1,
        PH_RX2   = 3'd2,
        PH_RX3   = 3'd3,
        PH_RX4   = 3'd4,
        PH_END   = 3'd5,
        PH_START = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] frame_reg [FRAME_BYTES];
    logic [7:0] frame_next [FRAME_BYTES];
    logic [2:0] pending_reg, pending_next;
    logic       select_reg, select_next;
    logic [7:0] dead_zone_reg;
    logic       dir_enable_reg;
    logic [1:0] led_bits_reg;

    logic       accept;
    sjfp_out_t  result;

    logic [15:0]         x_cur;
    logic [15:0]         y_cur;
    logic [CENTER_W-1:0] thr_high;
    logic [CENTER_W-1:0] thr_low;

    assign x_cur    = {frame_reg[1], frame_reg[0]};
    assign y_cur    = {frame_reg[3], frame_reg[2]};
    assign thr_high = CENTER + {2'b00, dead_zone_reg};
    assign thr_low  = CENTER - {2'b00, dead_zone_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        select_next  = select_reg;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_next[i] = frame_reg[i];
        end
        result.send_valid = 1'b0;
        result.send_byte  = 8'h00;
        result.direction  = DIR_NONE;

        if (in_data.func == FUNC_READ)
        begin
            result.direction = pending_reg;
            pending_next     = DIR_NONE;
        end
        else
        begin
            case (phase_reg)
                PH_RX0, PH_RX1, PH_RX2, PH_RX3, PH_RX4:
                begin
                    if (in_data.byte_done)
                    begin
                        frame_next[phase_reg] = in_data.rx_byte;
                        // a dummy zero clocks out the next byte, except after the last
                        if (phase_reg != PH_RX4)
                        begin
                            result.send_valid = 1'b1;
                        end
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                end
                PH_END:
                begin
                    select_next = 1'b1;
                    phase_next  = PH_START;
                    if (dir_enable_reg)
                    begin
                        // later tests win
                        if (x_cur > {6'b0, thr_high})
                        begin
                            pending_next = DIR_X_HIGH;
                        end
                        if (x_cur < {6'b0, thr_low})
                        begin
                            pending_next = DIR_X_LOW;
                        end
                        if (y_cur > {6'b0, thr_high})
                        begin
                            pending_next = DIR_Y_HIGH;
                        end
                        if (y_cur < {6'b0, thr_low})
                        begin
                            pending_next = DIR_Y_LOW;
                        end
                    end
                end
                PH_START:
                begin
                    select_next       = 1'b0;
                    result.send_valid = 1'b1;
                    result.send_byte  = CMD_BASE | {6'b0, led_bits_reg & LED_MASK};
                    phase_next        = PH_RX0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        result.chip_select = select_next;
        result.x_value     = {frame_next[1], frame_next[0]};
        result.y_value     = {frame_next[3], frame_next[2]};
        result.buttons     = frame_next[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pending_reg <= DIR_NONE;
            select_reg  <= 1'b1;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            select_reg  <= select_next;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_reg[i] <= frame_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= 8'h00;
            dir_enable_reg <= 1'b0;
            led_bits_reg   <= 2'b00;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_data;
                CFG_DIR_ENABLE: dir_enable_reg <= cfg_data[0];
                CFG_LED_BITS:   led_bits_reg   <= cfg_data[1:0];
                default:
                begin
                    dead_zone_reg <= dead_zone_reg;
                end
            endcase
        end
    end

    assign accept = in_valid && in_ready;

    sjfp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/sjfp_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module sjfp_checker
    import sjfp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire sjfp_out_t out_data
);

    // a stalled result must not change under the receiver
    `SJFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // no byte started means the byte field is zero
    `SJFP_ASSERT_NOW(a_idle_byte, out_valid && !out_data.send_valid, out_data.send_byte == 8'h00, "send_byte set without send_valid")

    // a nonzero byte is only ever the command byte, sent with chip select low
    `SJFP_ASSERT_NOW(a_cmd_byte, out_valid && out_data.send_byte != 8'h00, out_data.send_byte[7:2] == 6'b100000 && !out_data.chip_select && out_data.send_valid, "bad command byte")

    // direction codes stay in range and come only with no byte started
    `SJFP_ASSERT_NOW(a_dir_code, out_valid && out_data.direction != DIR_NONE, out_data.direction <= DIR_Y_LOW && !out_data.send_valid, "bad direction result")

endmodule

bind spi_joystick_frame_poller_top sjfp_checker u_sjfp_checker (.*);

`default_nettype wire
